/* rtl/awa_pkg.sv */
`timescale 1ns / 1ps
package awa_pkg;

  localparam int STATE_W = 4;
  localparam int SYM_W   = 8;
  localparam int CFG_W   = 16;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_SYMBOL = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  // config register indexes
  localparam logic [0:0] REG_INITIAL_STATE = 1'd0;
  localparam logic [0:0] REG_FINAL_MASK    = 1'd1;

  typedef struct packed {
    mode_t              mode;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               no_transition;
    logic [STATE_W-1:0] end_state;
  } out_item_t;

  // search token that walks down the cell row
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [STATE_W-1:0] state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] next_state;
  } query_t;

  // one table entry
  typedef struct packed {
    logic [STATE_W-1:0] source;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] target;
  } entry_t;

endpackage

/* rtl/automaton_word_acceptor_top.sv */
`timescale 1ns / 1ps
// Table-driven finite automaton that accepts or rejects words. Items clear the
// transition table, append a transition, feed one word symbol or end the word;
// only an end-of-word item produces a result item (accepted, no_transition,
// end_state). The table lives in a row of TABLE_DEPTH cells, one entry each. A
// symbol item launches a search token that moves one cell per cycle; the first
// in-range cell that matches the current state and symbol stamps its target
// into the token. A symbol item therefore occupies the block until its token
// has walked the whole row, and no new item is taken meanwhile; clear, append,
// end-of-word and symbols on a dead word start no search. in_stall is
// high during a search and while an undelivered result item is held stalled.
// Appends to a full table are dropped. Writing initial_state while idle restarts the word.
module automaton_word_acceptor_top #(
  parameter int TABLE_DEPTH = 32,
  parameter int STATE_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  awa_pkg::in_item_t             in_item,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output awa_pkg::out_item_t            out_item,
  // configuration
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [awa_pkg::CFG_W-1:0]     cfg_data
);
  import awa_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } ctrl_state_t;

  ctrl_state_t        state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [STATE_W-1:0] cur_r, cur_nxt;
  logic               dead_r, dead_nxt;
  logic [STATE_W-1:0] init_r;
  logic [15:0]        mask_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               in_fire;
  logic               out_fire;
  logic               launch;
  logic               append_ok;
  logic               cur_final;

  query_t             chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] chain_valid;
  entry_t             wr_entry;

  assign out_fire = out_valid_r && !out_stall;
  // the output register frees up in the same cycle it is taken
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_fire  = in_valid && !in_stall;

  assign append_ok = in_fire && in_item.mode == MODE_APPEND &&
                     count_r < CW'(TABLE_DEPTH);
  assign launch    = in_fire && in_item.mode == MODE_SYMBOL && !dead_r;

  assign wr_entry.source = in_item.from_state;
  assign wr_entry.symbol = in_item.symbol;
  assign wr_entry.target = in_item.to_state;

  // head of the row: token carries the current state and the symbol
  always_comb begin
    chain[0]            = '0;
    chain[0].valid      = launch;
    chain[0].state      = cur_r;
    chain[0].symbol     = in_item.symbol;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(g);
    awa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (append_ok && count_r == IDX),
      .wr_entry (wr_entry),
      .in_range (IDX < count_r),
      .q_in     (chain[g]),
      .q_out    (chain[g+1])
    );
    assign chain_valid[g] = chain[g+1].valid;
  end

  // states at or above STATE_COUNT never accept
  assign cur_final = (int'(cur_r) < STATE_COUNT) && mask_r[cur_r];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    dead_nxt      = dead_r;
    out_valid_nxt = out_valid_r && !out_fire;
    out_item_nxt  = out_item_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_item.mode)
            MODE_CLEAR:  count_nxt = '0;
            MODE_APPEND: begin
              if (append_ok) count_nxt = count_r + 1'b1;
            end
            MODE_SYMBOL: begin
              if (!dead_r) state_nxt = ST_SEARCH;
            end
            MODE_END: begin
              out_valid_nxt              = 1'b1;
              out_item_nxt.accepted      = !dead_r && cur_final;
              out_item_nxt.no_transition = dead_r;
              out_item_nxt.end_state     = cur_r;
              cur_nxt                    = init_r;
              dead_nxt                   = 1'b0;
            end
            default: ;
          endcase
        end
        // config must arrive only while idle; the block itself does not enforce it
        if (cfg_we && cfg_index == REG_INITIAL_STATE) begin
          cur_nxt  = cfg_data[STATE_W-1:0];
          dead_nxt = 1'b0;
        end
      end
      ST_SEARCH: begin
        // token leaves the last cell
        if (chain[TABLE_DEPTH].valid) begin
          state_nxt = ST_IDLE;
          if (chain[TABLE_DEPTH].hit) begin
            cur_nxt = chain[TABLE_DEPTH].next_state;
          end else begin
            dead_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      dead_r      <= 1'b0;
      init_r      <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      dead_r      <= dead_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_INITIAL_STATE) init_r <= cfg_data[STATE_W-1:0];
      if (cfg_we && cfg_index == REG_FINAL_MASK)    mask_r <= cfg_data[15:0];
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // at most one token in flight
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_valid))
    else $error("more than one search token in the cell row");

  // a token only exits while the controller waits for it
  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    chain[TABLE_DEPTH].valid |-> state_r == ST_SEARCH)
    else $error("search token exited outside a search");

  // no new item while a search runs
  a_stall_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> in_stall)
    else $error("input accepted during search");

  // fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // a launched symbol search moves the controller into search
  a_launch_search: assert property (@(posedge clk) disable iff (!rst_n)
    launch |=> state_r == ST_SEARCH)
    else $error("symbol launched without search");

endmodule

/* rtl/awa_cell.sv */
`timescale 1ns / 1ps
module awa_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  awa_pkg::entry_t wr_entry,
  input  logic            in_range,
  input  awa_pkg::query_t q_in,
  output awa_pkg::query_t q_out
);
  import awa_pkg::*;

  entry_t entry_r;
  query_t q_r;
  query_t q_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_entry;
    end
  end

  // first match along the row wins; later cells only pass the token on
  always_comb begin
    q_nxt = q_in;
    if (q_in.valid && !q_in.hit && in_range &&
        entry_r.source == q_in.state && entry_r.symbol == q_in.symbol) begin
      q_nxt.hit        = 1'b1;
      q_nxt.next_state = entry_r.target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r.valid <= q_nxt.valid;
    end
    q_r.hit        <= q_nxt.hit;
    q_r.state      <= q_nxt.state;
    q_r.symbol     <= q_nxt.symbol;
    q_r.next_state <= q_nxt.next_state;
  end

  assign q_out = q_r;

endmodule

/* tb/automaton_word_acceptor_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the word acceptor. A driver and a monitor run as clocked
// always blocks. An initial block fills the queue of pending items phase by phase
// and writes the two registers between phases, while the block is idle. A local
// automaton mirrors the table and the word in progress and queues one expected
// verdict per end-of-word item.
module automaton_word_acceptor_top_tb;
  import awa_pkg::*;

  localparam int TABLE_DEPTH    = 32;
  localparam int STATE_COUNT    = 16;
  localparam int ITEM_TARGET    = 850;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RX_HOLD_CYCLES = 600;
  // A symbol search walks the whole row, so leave room for one before touching cfg.
  localparam int SETTLE_CYCLES  = 2 * TABLE_DEPTH + 8;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_we    = 1'b0;
  logic [0:0]       cfg_index = REG_INITIAL_STATE;
  logic [CFG_W-1:0] cfg_data  = '0;

  automaton_word_acceptor_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .STATE_COUNT(STATE_COUNT)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mirror of the automaton: transition table, word in progress, registers.
  // Table entries at or above tbl_used are never looked at.
  // ---------------------------------------------------------------------------
  logic [STATE_W-1:0] tbl_from [TABLE_DEPTH];
  logic [SYM_W-1:0]   tbl_sym  [TABLE_DEPTH];
  logic [STATE_W-1:0] tbl_to   [TABLE_DEPTH];
  int                 tbl_used       = 0;
  logic [STATE_W-1:0] cur_state      = '0;
  logic [STATE_W-1:0] init_state_reg = '0;
  logic [15:0]        final_mask_reg = '0;
  bit                 word_dead      = 1'b0;

  in_item_t  pending_items[$];     // items waiting for the driver
  out_item_t expected_verdicts[$]; // verdicts owed by the block, oldest first

  int fail_count      = 0;
  int items_taken     = 0; // every item the block accepted
  int effective_items = 0; // items that changed something, ignored ones excluded
  int symbols_walked  = 0;
  int appends_dropped = 0;
  int verdicts_seen   = 0;
  int accepted_seen   = 0;
  int dead_seen       = 0;
  int cycle_count     = 0;

  // traffic shaping knobs, changed by the stimulus process at falling edges
  int send_idle_pct = 0;
  int rx_stall_pct  = 0;
  bit rx_hold_req   = 1'b0;
  int rx_hold_left  = 0;

  // States at or above STATE_COUNT have no mask bit and never accept.
  function automatic bit state_accepts(input logic [STATE_W-1:0] s);
    if (int'(s) >= STATE_COUNT) return 1'b0;
    return final_mask_reg[s];
  endfunction

  // Apply one accepted item to the mirror; an end of word queues its verdict.
  task automatic dfa_advance(input in_item_t it);
    out_item_t verdict;
    bit        found;
    found = 1'b0;
    items_taken++;
    case (it.mode)
      MODE_CLEAR: begin
        // only the table goes; the word in progress is left alone
        tbl_used = 0;
        effective_items++;
      end
      MODE_APPEND: begin
        if (tbl_used < TABLE_DEPTH) begin
          tbl_from[tbl_used] = it.from_state;
          tbl_sym[tbl_used]  = it.symbol;
          tbl_to[tbl_used]   = it.to_state;
          tbl_used++;
          effective_items++;
        end else begin
          appends_dropped++;
        end
      end
      MODE_SYMBOL: begin
        // a dead word swallows its later symbols
        if (!word_dead) begin
          effective_items++;
          symbols_walked++;
          // first match in insertion order wins
          for (int i = 0; i < tbl_used; i++) begin
            if (!found && tbl_from[i] == cur_state && tbl_sym[i] == it.symbol) begin
              cur_state = tbl_to[i];
              found     = 1'b1;
            end
          end
          if (!found) word_dead = 1'b1;
        end
      end
      MODE_END: begin
        verdict.accepted      = !word_dead && state_accepts(cur_state);
        verdict.no_transition = word_dead;
        verdict.end_state     = cur_state;
        expected_verdicts     = {expected_verdicts, verdict};
        cur_state = init_state_reg;
        word_dead = 1'b0;
        effective_items++;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: the mirror sees an item at the edge where the block takes it.
  // in_valid is only lowered after an accept or while it is already low, so
  // a stalled item stays put.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) dfa_advance(in_item);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here; armed by the stimulus process.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_left <= 0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req) begin
      rx_hold_left <= RX_HOLD_CYCLES;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every verdict taken is checked against the oldest one expected.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : verdict_check
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("result item with none expected: end_state %0d", out_item.end_state);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          verdicts_seen++;
          if (out_item.accepted) accepted_seen++;
          if (out_item.no_transition) dead_seen++;
          if (out_item.accepted !== want.accepted) begin
            $error("accepted: expected %0b, got %0b", want.accepted, out_item.accepted);
            fail_count++;
          end
          if (out_item.no_transition !== want.no_transition) begin
            $error("no_transition: expected %0b, got %0b",
                   want.no_transition, out_item.no_transition);
            fail_count++;
          end
          if (out_item.end_state !== want.end_state) begin
            $error("end_state: expected %0d, got %0d", want.end_state, out_item.end_state);
            fail_count++;
          end
        end
      end
      out_stall <= (rx_hold_left != 0) || ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic offer(input mode_t m, input logic [SYM_W-1:0] s,
                       input logic [STATE_W-1:0] f, input logic [STATE_W-1:0] t);
    in_item_t it;
    it.mode       = m;
    it.symbol     = s;
    it.from_state = f;
    it.to_state   = t;
    pending_items = {pending_items, it};
  endtask

  // Register write; the mirror follows at the edge where the block takes it.
  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INITIAL_STATE) begin
      // writing the start state restarts the word, dead or not
      init_state_reg = val[STATE_W-1:0];
      cur_state      = val[STATE_W-1:0];
      word_dead      = 1'b0;
    end else if (idx == REG_FINAL_MASK) begin
      final_mask_reg = val;
    end
  endtask

  // Sender pause: everything taken, every verdict back, then room for a
  // trailing symbol search that produces nothing visible.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One session: clear, build a small random automaton around the start state,
  // then run words over its alphabet. With overfill the table is padded past
  // its depth so trailing appends are dropped.
  task automatic queue_session(input bit overfill);
    logic [STATE_W-1:0] states[$];
    logic [SYM_W-1:0]   alphabet[$];
    int                 n_states;
    int                 n_syms;
    int                 entries;
    int                 budget;
    int                 len;
    n_states = $urandom_range(2, 6);
    n_syms   = $urandom_range(1, 4);
    entries  = 0;
    budget   = 0;
    states   = {states, init_state_reg};
    repeat (n_states - 1) states = {states, STATE_W'($urandom_range(15))};
    repeat (n_syms) alphabet = {alphabet, SYM_W'($urandom_range(255))};
    offer(MODE_CLEAR, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
    budget++;
    foreach (states[i]) begin
      foreach (alphabet[j]) begin
        if ($urandom_range(9) < 8) begin
          offer(MODE_APPEND, alphabet[j], states[i], states[$urandom_range(n_states - 1)]);
          entries++;
          budget++;
          // now and then a shadowed duplicate; the earlier entry must win
          if ($urandom_range(7) == 0) begin
            offer(MODE_APPEND, alphabet[j], states[i], STATE_W'($urandom));
            entries++;
            budget++;
          end
        end
      end
    end
    if (overfill) begin
      while (entries < TABLE_DEPTH) begin
        offer(MODE_APPEND, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
        entries++;
        budget++;
      end
      // table is full: these go nowhere
      offer(MODE_APPEND, alphabet[0], init_state_reg, states[1]);
      offer(MODE_APPEND, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
      budget += 2;
    end
    while (budget < 95) begin
      len = $urandom_range(0, 8);
      repeat (len) begin
        if ($urandom_range(9) == 0)
          offer(MODE_SYMBOL, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
        else
          offer(MODE_SYMBOL, alphabet[$urandom_range(n_syms - 1)],
                STATE_W'($urandom), STATE_W'($urandom));
        budget++;
      end
      // rare stray item inside a word
      case ($urandom_range(29))
        0: offer(MODE_CLEAR, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
        1: offer(MODE_APPEND, alphabet[$urandom_range(n_syms - 1)],
                 states[$urandom_range(n_states - 1)], states[$urandom_range(n_states - 1)]);
        default: ;
      endcase
      offer(MODE_END, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
      budget++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling. Start state 0 and top state both accept.
    write_reg(REG_INITIAL_STATE, 16'd0);
    write_reg(REG_FINAL_MASK, 16'h8001);
    @(negedge clk);
    offer(MODE_END, 8'h00, 4'h0, 4'h0);      // empty word, start state accepts
    offer(MODE_SYMBOL, 8'h55, 4'h0, 4'h0);   // empty table: word dies
    offer(MODE_SYMBOL, 8'hFF, 4'hF, 4'hF);   // ignored after death
    offer(MODE_END, 8'hFF, 4'hF, 4'hF);
    offer(MODE_APPEND, 8'hFF, 4'h0, 4'hF);
    offer(MODE_APPEND, 8'hFF, 4'h0, 4'h3);   // shadowed by the entry above
    offer(MODE_APPEND, 8'h00, 4'hF, 4'h0);
    offer(MODE_SYMBOL, 8'hFF, 4'h0, 4'h0);
    offer(MODE_END, 8'h00, 4'h0, 4'h0);
    offer(MODE_SYMBOL, 8'hFF, 4'h0, 4'h0);
    offer(MODE_SYMBOL, 8'h00, 4'h0, 4'h0);
    offer(MODE_SYMBOL, 8'hFF, 4'h0, 4'h0);
    offer(MODE_END, 8'h00, 4'h0, 4'h0);
    offer(MODE_SYMBOL, 8'hFF, 4'h0, 4'h0);
    offer(MODE_CLEAR, 8'hFF, 4'hF, 4'hF);    // word in progress survives the clear
    offer(MODE_END, 8'h00, 4'h0, 4'h0);
    offer(MODE_SYMBOL, 8'hFF, 4'h0, 4'h0);   // table now empty: dies
    offer(MODE_END, 8'h00, 4'h0, 4'h0);
    wait_idle();

    // Top start state with an empty mask; leave a word running into the next write.
    write_reg(REG_INITIAL_STATE, 16'd15);
    write_reg(REG_FINAL_MASK, 16'h0000);
    @(negedge clk);
    offer(MODE_END, 8'h00, 4'h0, 4'h0);
    offer(MODE_APPEND, 8'hAA, 4'hF, 4'h9);
    offer(MODE_SYMBOL, 8'hAA, 4'h0, 4'h0);
    wait_idle();

    // Start-state write restarts that word; full mask.
    write_reg(REG_INITIAL_STATE, 16'd0);
    write_reg(REG_FINAL_MASK, 16'hFFFF);
    @(negedge clk);
    offer(MODE_END, 8'h00, 4'h0, 4'h0);
    offer(MODE_SYMBOL, 8'h11, 4'h0, 4'h0);   // dead word left for the next restart
    wait_idle();

    // Random sessions, rotating through the idling patterns. Each phase starts
    // from a drained block and writes both registers.
    phase = 0;
    while (items_taken < ITEM_TARGET) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 63; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 63; end
        default: begin send_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      case (phase)
        0: begin
          write_reg(REG_INITIAL_STATE, 16'd15);
          write_reg(REG_FINAL_MASK, 16'hFFFF);
        end
        1: begin
          write_reg(REG_INITIAL_STATE, 16'd0);
          write_reg(REG_FINAL_MASK, 16'h0000);
        end
        default: begin
          write_reg(REG_INITIAL_STATE, CFG_W'($urandom_range(15)));
          write_reg(REG_FINAL_MASK, CFG_W'($urandom_range(16'hFFFF)));
        end
      endcase
      @(negedge clk);
      // Once: receiver holds off for a long stretch while items keep coming,
      // so a held verdict backs up into in_stall.
      if (phase == 2) begin
        rx_hold_req = 1'b1;
        while (rx_hold_left == 0) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      queue_session(phase == 0 || $urandom_range(5) == 0);
      wait_idle();
      phase++;
    end

    $display("Covered %0d items (%0d effective) over %0d phases",
             items_taken, effective_items, phase);
    $display("%0d symbol searches, %0d appends dropped, %0d words ended: %0d accepted, %0d dead",
             symbols_walked, appends_dropped, verdicts_seen, accepted_seen, dead_seen);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/awa_pkg.sv
rtl/awa_cell.sv
rtl/automaton_word_acceptor_top.sv
tb/automaton_word_acceptor_top_tb.sv
